/* sv/mcppm_pkg.sv */
// shared types, constants and helpers for the pulse period meter
package mcppm_pkg;

   // channel count and field widths
   localparam int NumChannels  = 4;
   localparam int ChanBits     = 2;
   localparam int CountBits    = 16;
   localparam int StampBits    = 32;
   localparam int DivBits      = 17;
   localparam int EnableBits   = 4;
   localparam int CsrDataBits  = 17;
   localparam int CsrIndexBits = 2;

   // request queue between front and back
   localparam int QueueDepth   = 2;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   // request type codes on the input channel
   localparam logic [1:0] REQ_OVERFLOW = 2'd0;
   localparam logic [1:0] REQ_CAPTURE  = 2'd1;
   localparam logic [1:0] REQ_READ     = 2'd2;

   // configuration register indexes
   localparam logic [CsrIndexBits-1:0] CSR_COUNTER_TOP    = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_CLOCK_DIVIDER  = 2'd1;
   localparam logic [CsrIndexBits-1:0] CSR_CHANNEL_ENABLE = 2'd2;

   // fixed values
   localparam logic [CountBits-1:0] FullTop        = 16'hffff;
   localparam logic [StampBits-1:0] LostMark       = 32'hffff_ffff;
   localparam logic [DivBits-1:0]   DividerReset   = 17'd1;
   localparam logic [EnableBits-1:0] EnableReset   = 4'hf;

   // command classes held in the queue
   typedef enum logic [1:0] {
      CMD_OVERFLOW,
      CMD_CAPTURE,
      CMD_READ
   } cmd_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [ChanBits-1:0]   channel;
      logic [CountBits-1:0]  count;
   } entry_type;

   typedef struct packed {
      logic [CountBits-1:0]  counter_top;
      logic [DivBits-1:0]    clock_divider;
      logic [EnableBits-1:0] channel_enable;
   } cfg_type;

   // front to queue
   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   // queue to back
   typedef struct packed {
      logic      avail;
      entry_type entry;
   } head_type;

   // enable bits limited to channels that exist
   function automatic logic [EnableBits-1:0] active_mask(input logic [EnableBits-1:0] en);
      logic [EnableBits-1:0] m;
      for (int i = 0; i < EnableBits; i++) begin
         m[i] = en[i] && (i < NumChannels);
      end
      return m;
   endfunction

endpackage

/* sv/mcppm_front.sv */
// front end: accepts requests, drops those with no effect, queues the rest
module mcppm_front (
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_req_type,
   input  logic [mcppm_pkg::ChanBits-1:0]  req_channel,
   input  logic [mcppm_pkg::CountBits-1:0] req_capture_count,
   input  logic [mcppm_pkg::CountBits-1:0] req_counter_now,
   input  mcppm_pkg::cfg_type              cfg,
   input  logic                            q_full,
   output mcppm_pkg::push_type             push
);

   logic [mcppm_pkg::EnableBits-1:0] mask;
   logic                             keep;
   mcppm_pkg::entry_type             entry;

   assign mask = mcppm_pkg::active_mask(cfg.channel_enable);

   // classify the request
   always_comb begin
      keep          = 1'b0;
      entry.cmd     = mcppm_pkg::CMD_READ;
      entry.channel = req_channel;
      entry.count   = req_counter_now;
      case (req_req_type)
         mcppm_pkg::REQ_OVERFLOW: begin
            // extension only counts at full range
            keep      = (cfg.counter_top == mcppm_pkg::FullTop);
            entry.cmd = mcppm_pkg::CMD_OVERFLOW;
         end
         mcppm_pkg::REQ_CAPTURE: begin
            keep        = mask[req_channel];
            entry.cmd   = mcppm_pkg::CMD_CAPTURE;
            entry.count = req_capture_count;
         end
         mcppm_pkg::REQ_READ: begin
            keep      = |mask;
            entry.cmd = mcppm_pkg::CMD_READ;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // handshake toward the queue
   assign req_stall  = q_full;
   assign push.push  = req_valid && !q_full && keep;
   assign push.entry = entry;

endmodule

/* sv/mcppm_queue.sv */
// short request queue between front and back
module mcppm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  mcppm_pkg::push_type  push,
   output logic                 full,
   input  logic                 pop,
   output mcppm_pkg::head_type  head
);

   mcppm_pkg::entry_type                   slot_ff [mcppm_pkg::QueueDepth];
   logic [mcppm_pkg::QueuePtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mcppm_pkg::QueuePtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mcppm_pkg::QueueCntBits-1:0]     cnt_ff, cnt_in;
   logic                                   do_push, do_pop;

   assign full    = (cnt_ff == mcppm_pkg::QueueCntBits'(mcppm_pkg::QueueDepth));
   assign do_push = push.push && !full;
   assign do_pop  = pop && (cnt_ff != '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head.avail = (cnt_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

endmodule

/* sv/mcppm_back.sv */
// back end: timer state, capture bookkeeping and the per-channel read walk
module mcppm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  mcppm_pkg::cfg_type              cfg,
   input  mcppm_pkg::head_type             head,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mcppm_pkg::ChanBits-1:0]  rsp_out_channel,
   output logic [mcppm_pkg::StampBits-1:0] rsp_period,
   output logic                            rsp_signal_lost,
   output logic                            rsp_last_of_run
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   localparam int ProdBits = mcppm_pkg::StampBits + mcppm_pkg::DivBits;

   state_type                          state_ff, state_in;
   logic [mcppm_pkg::ChanBits-1:0]     ch_ff, ch_in;
   logic [mcppm_pkg::StampBits-1:0]    now_ff, now_in;
   logic [mcppm_pkg::CountBits-1:0]    ovf_ff, ovf_in;
   logic [mcppm_pkg::StampBits-1:0]    meas_ff [mcppm_pkg::NumChannels];
   logic [mcppm_pkg::StampBits-1:0]    meas_in [mcppm_pkg::NumChannels];
   logic [mcppm_pkg::StampBits-1:0]    cap_ff  [mcppm_pkg::NumChannels];
   logic [mcppm_pkg::StampBits-1:0]    cap_in  [mcppm_pkg::NumChannels];
   logic [mcppm_pkg::StampBits-1:0]    rep_ff  [mcppm_pkg::NumChannels];
   logic [mcppm_pkg::StampBits-1:0]    rep_in  [mcppm_pkg::NumChannels];
   logic [mcppm_pkg::StampBits-1:0]    rst_ff  [mcppm_pkg::NumChannels];
   logic [mcppm_pkg::StampBits-1:0]    rst_in  [mcppm_pkg::NumChannels];
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mcppm_pkg::ChanBits-1:0]     rsp_chan_ff, rsp_chan_in;
   logic [mcppm_pkg::StampBits-1:0]    rsp_period_ff, rsp_period_in;
   logic                               rsp_lost_ff, rsp_lost_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [mcppm_pkg::EnableBits-1:0]   mask;
   logic [mcppm_pkg::ChanBits-1:0]     last_ch;
   logic                               out_free;
   logic                               rsp_load;
   logic [ProdBits-1:0]                product;
   logic [mcppm_pkg::StampBits-1:0]    elapsed;
   logic [mcppm_pkg::StampBits-1:0]    limit;
   logic [mcppm_pkg::StampBits-1:0]    stamp;
   logic [mcppm_pkg::StampBits-1:0]    new_rep;

   assign mask = mcppm_pkg::active_mask(cfg.channel_enable);

   // highest enabled channel closes the run
   always_comb begin
      last_ch = '0;
      for (int i = 0; i < mcppm_pkg::EnableBits; i++) begin
         if (mask[i]) begin
            last_ch = mcppm_pkg::ChanBits'(i);
         end
      end
   end

   // per-channel datapath for the walk
   assign product  = {{mcppm_pkg::DivBits{1'b0}}, meas_ff[ch_ff]}
                   * {{mcppm_pkg::StampBits{1'b0}}, cfg.clock_divider};
   assign elapsed  = now_ff - cap_ff[ch_ff];
   assign limit    = {meas_ff[ch_ff][mcppm_pkg::StampBits-4:0], 3'b000};
   assign stamp    = {ovf_ff, head.entry.count};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      now_in        = now_ff;
      ovf_in        = ovf_ff;
      meas_in       = meas_ff;
      cap_in        = cap_ff;
      rep_in        = rep_ff;
      rst_in        = rst_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_chan_in   = rsp_chan_ff;
      rsp_period_in = rsp_period_ff;
      rsp_lost_in   = rsp_lost_ff;
      rsp_last_in   = rsp_last_ff;
      pop           = 1'b0;
      rsp_load      = 1'b0;
      new_rep       = rep_ff[ch_ff];
      case (state_ff)
         ST_IDLE: begin
            if (head.avail) begin
               pop = 1'b1;
               case (head.entry.cmd)
                  mcppm_pkg::CMD_OVERFLOW: begin
                     ovf_in = ovf_ff + 1'b1;
                  end
                  mcppm_pkg::CMD_CAPTURE: begin
                     meas_in[head.entry.channel] = stamp - cap_ff[head.entry.channel];
                     cap_in[head.entry.channel]  = stamp;
                  end
                  mcppm_pkg::CMD_READ: begin
                     now_in   = {ovf_ff, head.entry.count & cfg.counter_top};
                     ch_in    = '0;
                     state_in = ST_WALK;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (!mask[ch_ff] || out_free) begin
               if (mask[ch_ff]) begin
                  // new stamp, silent too long, or repeat
                  if (rst_ff[ch_ff] != cap_ff[ch_ff]) begin
                     new_rep       = product[mcppm_pkg::StampBits-1:0];
                     rst_in[ch_ff] = cap_ff[ch_ff];
                  end else if (elapsed > limit) begin
                     new_rep = mcppm_pkg::LostMark;
                  end
                  rep_in[ch_ff] = new_rep;
                  rsp_load      = 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_chan_in   = ch_ff;
                  rsp_period_in = new_rep;
                  rsp_lost_in   = (new_rep == mcppm_pkg::LostMark);
                  rsp_last_in   = (ch_ff == last_ch);
               end
               if (ch_ff == last_ch || ch_ff == '1) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         ovf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < mcppm_pkg::NumChannels; i++) begin
            meas_ff[i] <= {{(mcppm_pkg::StampBits - mcppm_pkg::CountBits){1'b0}},
                           mcppm_pkg::FullTop};
            cap_ff[i]  <= '0;
            rep_ff[i]  <= '0;
            rst_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         meas_ff      <= meas_in;
         cap_ff       <= cap_in;
         rep_ff       <= rep_in;
         rst_ff       <= rst_in;
      end
      now_ff        <= now_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_period_ff <= rsp_period_in;
      rsp_lost_ff   <= rsp_lost_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_period      = rsp_period_ff;
   assign rsp_signal_lost = rsp_lost_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // queue is only drained between runs
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE)
      else $error("queue popped during a read walk");

   // overflow advances the extension by exactly one
   a_ovf_step: assert property (@(posedge clock) disable iff (reset)
      (pop && head.entry.cmd == mcppm_pkg::CMD_OVERFLOW) |=> ovf_ff == $past(ovf_ff) + 1'b1)
      else $error("overflow count did not advance");

   // the last result of a run ends the walk
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> state_ff == ST_IDLE)
      else $error("walk continued past the last enabled channel");

   // results only come from enabled channels
   a_enabled_only: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> mask[ch_ff])
      else $error("result from a disabled channel");

   // lost flag agrees with the held period
   a_lost_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_lost_ff == (rsp_period_ff == mcppm_pkg::LostMark))
      else $error("lost flag does not match period");

endmodule

/* sv/multi_channel_pulse_period_meter_core.sv */
// top level of the four-channel pulse period meter
// results: a read waits in the queue, then is popped into the walk state, which
//    loads the registered outputs, one result per enabled channel, lowest first
// execution: overflow and capture requests finish in the idle state when popped;
//    a read walks each channel up to the last enabled one, holding on rsp_stall;
//    no request is popped mid-walk; one multiply and compare path serves the walk
// reset: synchronous; clears the queue, overflow count, stamps and reports,
//    and loads counter_top 65535, divider 1, all channels enabled
module multi_channel_pulse_period_meter_core (
   input  logic                               clock,
   input  logic                               reset,
   // configuration writes
   input  logic                               csr_write_enable,
   input  logic [mcppm_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [mcppm_pkg::CsrDataBits-1:0]  csr_write_data,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_req_type,
   input  logic [mcppm_pkg::ChanBits-1:0]     req_channel,
   input  logic [mcppm_pkg::CountBits-1:0]    req_capture_count,
   input  logic [mcppm_pkg::CountBits-1:0]    req_counter_now,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mcppm_pkg::ChanBits-1:0]     rsp_out_channel,
   output logic [mcppm_pkg::StampBits-1:0]    rsp_period,
   output logic                               rsp_signal_lost,
   output logic                               rsp_last_of_run
);

   mcppm_pkg::cfg_type  cfg_ff, cfg_in;
   mcppm_pkg::push_type push;
   mcppm_pkg::head_type head;
   logic                q_full;
   logic                pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mcppm_pkg::CSR_COUNTER_TOP: begin
               cfg_in.counter_top = csr_write_data[mcppm_pkg::CountBits-1:0];
            end
            mcppm_pkg::CSR_CLOCK_DIVIDER: begin
               cfg_in.clock_divider = csr_write_data[mcppm_pkg::DivBits-1:0];
            end
            mcppm_pkg::CSR_CHANNEL_ENABLE: begin
               cfg_in.channel_enable = csr_write_data[mcppm_pkg::EnableBits-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counter_top    <= mcppm_pkg::FullTop;
         cfg_ff.clock_divider  <= mcppm_pkg::DividerReset;
         cfg_ff.channel_enable <= mcppm_pkg::EnableReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request classification
   mcppm_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_req_type      (req_req_type),
      .req_channel       (req_channel),
      .req_capture_count (req_capture_count),
      .req_counter_now   (req_counter_now),
      .cfg               (cfg_ff),
      .q_full            (q_full),
      .push              (push)
   );

   // decoupling queue
   mcppm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (pop),
      .head  (head)
   );

   // execution and result generation
   mcppm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_period      (rsp_period),
      .rsp_signal_lost (rsp_signal_lost),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* tb/multi_channel_pulse_period_meter_core_tb.sv */
// self-checking testbench for the four-channel pulse period meter core
`timescale 1ns / 1ps

module multi_channel_pulse_period_meter_core_tb;
   import mcppm_pkg::*;

   // codes with no name in the package
   localparam logic [1:0]              REQ_UNUSED = 2'd3;
   localparam logic [CsrIndexBits-1:0] CSR_SPARE  = 2'd3;

   localparam int DrainCycles  = 24;
   localparam int CycleLimit   = 200000;
   localparam int PhaseCount   = 8;
   localparam int PhaseQuota   = 50;
   localparam int ScriptLength = 37;

   typedef enum logic {STEP_REQUEST, STEP_WRITE} step_kind;

   // one row of the directed script: a request or a register write
   typedef struct packed {
      step_kind     kind;
      logic [1:0]   code;
      logic [1:0]   chan;
      logic [16:0]  value;
      logic [15:0]  cnow;
      logic         typed;
      logic [31:0]  typed_period;
   } step_row;

   // one reported period as it should leave the block
   typedef struct packed {
      logic [ChanBits-1:0]  chan;
      logic [StampBits-1:0] period;
      logic                 lost;
      logic                 last;
   } period_report;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0]  csr_write_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_req_type = '0;
   logic [ChanBits-1:0]     req_channel = '0;
   logic [CountBits-1:0]    req_capture_count = '0;
   logic [CountBits-1:0]    req_counter_now = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [ChanBits-1:0]     rsp_out_channel;
   logic [StampBits-1:0]    rsp_period;
   logic                    rsp_signal_lost;
   logic                    rsp_last_of_run;

   // expected reports, oldest first
   period_report pending_reports[$];
   int           errors = 0;
   int           cycle_count = 0;
   bit           calm = 1'b0;

   // meter state as the predictor sees it
   logic [15:0] cfg_top;
   logic [16:0] cfg_div;
   logic [3:0]  cfg_en;
   logic [15:0] ovf_count;
   logic [31:0] meas_period [NumChannels];
   logic [31:0] cap_stamp   [NumChannels];
   logic [31:0] rep_period  [NumChannels];
   logic [31:0] rep_stamp   [NumChannels];

   step_row script [0:ScriptLength-1] = '{
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'h0000, 1'b1, 32'h0},
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'hffff, 1'b1, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd0, 17'h00064, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd0, 17'h0ffff, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd3, 17'h08000, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_UNUSED,   2'd3, 17'h0ffff, 16'hffff, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_OVERFLOW, 2'd0, 17'h00000, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd1, 17'h00005, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'hffff, 1'b0, 32'h0},
      '{STEP_WRITE,   CSR_CLOCK_DIVIDER, 2'd0, 17'h10000, 16'h0, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd2, 17'h0000a, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd2, 17'h00014, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'h0000, 1'b0, 32'h0},
      '{STEP_WRITE,   CSR_CLOCK_DIVIDER, 2'd0, 17'h0ffff, 16'h0, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd0, 17'h00000, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_OVERFLOW, 2'd0, 17'h00000, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd0, 17'h00001, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'h0000, 1'b0, 32'h0},
      '{STEP_WRITE,   CSR_CHANNEL_ENABLE, 2'd0, 17'h00000, 16'h0, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd1, 17'h01234, 16'h0000, 1'b0, 32'h0},
      '{STEP_WRITE,   CSR_CHANNEL_ENABLE, 2'd0, 17'h0000a, 16'h0, 1'b0, 32'h0},
      '{STEP_WRITE,   CSR_COUNTER_TOP,    2'd0, 17'h000ff, 16'h0, 1'b0, 32'h0},
      '{STEP_WRITE,   CSR_SPARE,          2'd0, 17'h1ffff, 16'h0, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_OVERFLOW, 2'd0, 17'h00000, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd3, 17'h01234, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd0, 17'h04321, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'hffff, 1'b0, 32'h0},
      '{STEP_WRITE,   CSR_CLOCK_DIVIDER,  2'd0, 17'h00000, 16'h0, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_CAPTURE,  2'd1, 17'h00100, 16'h0000, 1'b0, 32'h0},
      '{STEP_REQUEST, REQ_READ,     2'd0, 17'h00000, 16'h0f0f, 1'b0, 32'h0},
      '{STEP_WRITE,   CSR_COUNTER_TOP,    2'd0, 17'h0ffff, 16'h0, 1'b0, 32'h0},
      '{STEP_WRITE,   CSR_CLOCK_DIVIDER,  2'd0, 17'h00001, 16'h0, 1'b0, 32'h0},
      '{STEP_WRITE,   CSR_CHANNEL_ENABLE, 2'd0, 17'h0000f, 16'h0, 1'b0, 32'h0}
   };

   multi_channel_pulse_period_meter_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_req_type      (req_req_type),
      .req_channel       (req_channel),
      .req_capture_count (req_capture_count),
      .req_counter_now   (req_counter_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_period        (rsp_period),
      .rsp_signal_lost   (rsp_signal_lost),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("multi_channel_pulse_period_meter_core_tb failed");
         $finish;
      end
   end

   // random back-pressure on the result side
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 11);
   end

   // meter state after reset
   task automatic reset_meter();
      cfg_top   = FullTop;
      cfg_div   = DividerReset;
      cfg_en    = EnableReset;
      ovf_count = '0;
      for (int i = 0; i < NumChannels; i++) begin
         meas_period[i] = {16'd0, FullTop};
         cap_stamp[i]   = '0;
         rep_period[i]  = '0;
         rep_stamp[i]   = '0;
      end
   endtask

   // predict one accepted request; queue the reports a read produces
   task automatic advance_meter(input logic [1:0] code, input logic [1:0] ch,
                                input logic [15:0] cap, input logic [15:0] cnow,
                                input logic use_typed, input logic [31:0] typed_period,
                                output bit effective);
      logic [31:0]  stamp;
      logic [31:0]  now;
      logic [31:0]  elapsed;
      logic [31:0]  lost_limit;
      logic [1:0]   last_ch;
      period_report rep;
      effective = 1'b0;
      case (code)
         REQ_OVERFLOW: begin
            if (cfg_top == FullTop) begin
               ovf_count = ovf_count + 16'd1;
               effective = 1'b1;
            end
         end
         REQ_CAPTURE: begin
            if (cfg_en[ch]) begin
               stamp           = {ovf_count, cap};
               meas_period[ch] = stamp - cap_stamp[ch];
               cap_stamp[ch]   = stamp;
               effective       = 1'b1;
            end
         end
         REQ_READ: begin
            if (cfg_en != '0) begin
               effective = 1'b1;
               last_ch   = '0;
               for (int i = 0; i < NumChannels; i++) begin
                  if (cfg_en[i]) last_ch = 2'(i);
               end
               now = {ovf_count, cnow & cfg_top};
               // walk enabled channels in ascending order
               for (int i = 0; i < NumChannels; i++) begin
                  if (cfg_en[i]) begin
                     elapsed    = now - cap_stamp[i];
                     lost_limit = meas_period[i] << 3;
                     if (rep_stamp[i] != cap_stamp[i]) begin
                        rep_period[i] = meas_period[i] * {15'd0, cfg_div};
                        rep_stamp[i]  = cap_stamp[i];
                     end else if (elapsed > lost_limit) begin
                        rep_period[i] = LostMark;
                     end
                     rep.chan   = 2'(i);
                     rep.period = use_typed ? typed_period : rep_period[i];
                     rep.lost   = (rep.period == LostMark);
                     rep.last   = (2'(i) == last_ch);
                     pending_reports.push_back(rep);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // drop valid and wait
   task automatic hold_off(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // wait for every report, then for the block to go quiet
   task automatic settle();
      hold_off(1);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // one register write, only while idle
   task automatic write_csr(input logic [CsrIndexBits-1:0] idx, input logic [16:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_COUNTER_TOP:    cfg_top = data[15:0];
         CSR_CLOCK_DIVIDER:  cfg_div = data;
         CSR_CHANNEL_ENABLE: cfg_en  = data[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // present one request and hold it until accepted
   task automatic send_request(input logic [1:0] code, input logic [1:0] ch,
                               input logic [15:0] cap, input logic [15:0] cnow,
                               input logic use_typed, input logic [31:0] typed_period,
                               output bit effective);
      logic taken;
      req_valid         <= 1'b1;
      req_req_type      <= code;
      req_channel       <= ch;
      req_capture_count <= cap;
      req_counter_now   <= cnow;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      advance_meter(code, ch, cap, cnow, use_typed, typed_period, effective);
   endtask

   // compare each accepted report with the oldest expectation
   always @(negedge clock) begin : check_reports
      period_report want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report channel %0d period %h", $time,
                     rsp_out_channel, rsp_period);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_out_channel !== want.chan) begin
               $display("%0t: out_channel expected %0d got %0d", $time,
                        want.chan, rsp_out_channel);
               errors++;
            end
            if (rsp_period !== want.period) begin
               $display("%0t: period expected %h got %h", $time, want.period, rsp_period);
               errors++;
            end
            if (rsp_signal_lost !== want.lost) begin
               $display("%0t: signal_lost expected %0b got %0b", $time,
                        want.lost, rsp_signal_lost);
               errors++;
            end
            if (rsp_last_of_run !== want.last) begin
               $display("%0t: last_of_run expected %0b got %0b", $time,
                        want.last, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      bit          effective;
      int          done;
      int          r;
      int          ovf_pct;
      logic [1:0]  code;
      logic [1:0]  ch;
      logic [15:0] cap;
      logic [15:0] new_top;
      logic [16:0] new_div;
      logic [3:0]  new_en;
      logic [15:0] next_cap [NumChannels];

      reset_meter();
      for (int i = 0; i < NumChannels; i++) next_cap[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed script
      for (int k = 0; k < ScriptLength; k++) begin
         if (script[k].kind == STEP_WRITE) begin
            settle();
            write_csr(script[k].code, script[k].value);
         end else begin
            send_request(script[k].code, script[k].chan, script[k].value[15:0],
                         script[k].cnow, script[k].typed, script[k].typed_period,
                         effective);
         end
      end

      // random phases, each under its own setting
      for (int phase = 0; phase < PhaseCount; phase++) begin
         settle();
         case (phase)
            0: begin new_top = FullTop; new_div = 17'd1;     new_en = 4'hf; end
            1: begin new_top = FullTop; new_div = 17'h10000; new_en = 4'h5; end
            2: begin new_top = 16'd1;   new_div = 17'd0;     new_en = 4'h8; end
            3: begin
               new_top = FullTop;
               new_div = 17'($urandom_range(65536, 1));
               new_en  = 4'($urandom_range(15, 1));
            end
            4: begin new_top = 16'd0;   new_div = 17'd65535; new_en = 4'hf; end
            default: begin
               new_top = $urandom_range(1) ? FullTop : 16'($urandom_range(65535));
               new_div = 17'($urandom_range(65536, 1));
               new_en  = 4'($urandom_range(15, 1));
            end
         endcase
         write_csr(CSR_COUNTER_TOP, {1'b0, new_top});
         write_csr(CSR_CLOCK_DIVIDER, new_div);
         write_csr(CSR_CHANNEL_ENABLE, {13'd0, new_en});
         calm    = (phase == 2);
         ovf_pct = (phase % 2 == 1) ? 35 : 15;
         done    = 0;
         while (done < PhaseQuota) begin
            if (!calm && $urandom_range(99) < 11) hold_off(1);
            r   = $urandom_range(99);
            ch  = 2'($urandom_range(3));
            cap = 16'($urandom_range(65535));
            if (r < ovf_pct) begin
               code = REQ_OVERFLOW;
            end else if (r < ovf_pct + 40) begin
               // mostly steady edges per channel, sometimes a wild count
               code = REQ_CAPTURE;
               if ($urandom_range(9) != 0) begin
                  cap = next_cap[ch] + 16'($urandom_range(4000, 1));
                  next_cap[ch] = cap;
               end
            end else if (r < 95) begin
               code = REQ_READ;
            end else begin
               code = REQ_UNUSED;
            end
            send_request(code, ch, cap, 16'($urandom_range(65535)), 1'b0, 32'h0, effective);
            if (effective) done++;
         end
      end

      calm = 1'b0;
      settle();
      if (errors == 0) begin
         $display("multi_channel_pulse_period_meter_core_tb passed");
      end else begin
         $display("multi_channel_pulse_period_meter_core_tb failed");
      end
      $finish;
   end

endmodule
